// File: hw/rtl/led_time_dither_modulator_top_defines.svh
// assertion macros used by the checker file
`ifndef LED_TIME_DITHER_MODULATOR_TOP_DEFINES_SVH
`define LED_TIME_DITHER_MODULATOR_TOP_DEFINES_SVH

// consequent checked in the same cycle
`define LTDM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define LTDM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/ltdm_pkg.sv
`default_nettype none

package ltdm_pkg;

	localparam int unsigned LEVEL_W   = 8;
	localparam int unsigned ELAPSED_W = 24;
	localparam int unsigned PERIOD_W  = 11;
	localparam int unsigned TIMEOUT_W = 29;
	localparam int unsigned TIME_W    = 21;
	localparam int unsigned ERR_W     = 32;
	localparam int unsigned HIGH_W    = 30;
	localparam int unsigned LOW_W     = 31;
	localparam int unsigned SUM_W     = 34;
	localparam int unsigned CFG_IDX_W = 1;

	localparam int unsigned MUL0_AW = ELAPSED_W;
	localparam int unsigned MUL1_AW = TIME_W;
	localparam int unsigned MUL_BW  = LEVEL_W;
	localparam int unsigned DIV0_NW = MUL0_AW + MUL_BW;
	localparam int unsigned DIV1_NW = MUL1_AW + MUL_BW;
	localparam int unsigned DIV_DW  = LEVEL_W;

	localparam logic [LEVEL_W-1:0] ON_LEVEL   = 8'd255;
	localparam logic [LEVEL_W-1:0] OFF_LEVEL  = 8'd0;
	localparam logic [LEVEL_W-1:0] HALF_LEVEL = ON_LEVEL / 2;
	localparam logic [LEVEL_W-1:0] SPAN       = ON_LEVEL - OFF_LEVEL;

	localparam logic [TIME_W-1:0]    US_PER_MS      = 21'd1000;
	localparam logic [PERIOD_W-1:0]  MIN_PERIOD_RST = 11'd10;
	localparam logic [PERIOD_W-1:0]  MAX_PERIOD_RST = 11'd1000;
	localparam logic [TIME_W-1:0]    MIN_OFF_RST    = 21'd10000;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX    = 29'h1FFF_FFFF;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD = 1'b1;

	typedef enum logic {
		OP_TIME = 1'b0,
		OP_SET  = 1'b1
	} op_t;

	typedef struct packed {
		op_t                  opcode;
		logic [ELAPSED_W-1:0] elapsed_us;
		logic [LEVEL_W-1:0]   brightness;
	} in_word_t;

	typedef struct packed {
		logic                 led_on;
		logic                 steady;
		logic [TIMEOUT_W-1:0] timeout_us;
	} out_word_t;

endpackage

`default_nettype wire

// File: hw/rtl/ltdm_mul.sv
`default_nettype none

module ltdm_mul #(
	parameter int unsigned AW = 24,
	parameter int unsigned BW = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic             done,
	output logic [AW+BW-1:0] p
);

	localparam int unsigned CW = $clog2(BW);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [AW-1:0]    a_q;
	logic [AW+BW-1:0] acc_q;
	logic [AW:0]      sum;

	// one multiplier bit per cycle, lsb first
	assign sum = {1'b0, acc_q[AW+BW-1:BW]} + (acc_q[0] ? {1'b0, a_q} : {(AW+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(BW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			acc_q <= {{AW{1'b0}}, b};
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[BW-1:1]};
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

`default_nettype wire

// File: hw/rtl/ltdm_div.sv
`default_nettype none

module ltdm_div #(
	parameter int unsigned NW = 32,
	parameter int unsigned DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] n,
	input  logic [DW-1:0] d,
	output logic          done,
	output logic [NW-1:0] q,
	output logic [DW-1:0] r
);

	localparam int unsigned CW = $clog2(NW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] d_q;
	logic [DW:0]   sh;
	logic [DW+1:0] diff;
	logic          fits;

	// restoring step, one quotient bit per cycle
	assign sh   = {rem_q, quo_q[NW-1]};
	assign diff = {1'b0, sh} - {2'b0, d_q};
	assign fits = !diff[DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(NW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= n;
			rem_q <= '0;
			d_q   <= d;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], fits};
			rem_q <= fits ? diff[DW-1:0] : sh[DW-1:0];
		end
	end

	assign done = done_q;
	assign q    = quo_q;
	assign r    = rem_q;

endmodule

`default_nettype wire

// File: hw/rtl/led_time_dither_modulator_top.sv
// a time event runs the accrual multiply, sum, clamp and choose steps, then the timeout divide
// unless the result is steady; a set-brightness event first runs a multiply, divide and multiply
// for the new limits; one word at a time, through the 8-step shift-add multipliers
// and the restoring dividers; a new word is taken while the last result waits
// reset: error, level and target cleared, limits as for target zero, periods 10 and 1000 ms
`default_nettype none

module led_time_dither_modulator_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  ltdm_pkg::in_word_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output ltdm_pkg::out_word_t                 out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ltdm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ltdm_pkg::PERIOD_W-1:0]       cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL1,
		S_DIV1,
		S_MUL2,
		S_ACC,
		S_SUM,
		S_CLAMP,
		S_CHOOSE,
		S_DIV2,
		S_FIN
	} state_t;

	function automatic logic [ltdm_pkg::LEVEL_W-1:0] speed_of(
		input logic                         lvl_on,
		input logic [ltdm_pkg::LEVEL_W-1:0] tgt
	);
		speed_of = lvl_on ? (ltdm_pkg::ON_LEVEL - tgt) : (tgt - ltdm_pkg::OFF_LEVEL);
	endfunction

	state_t state_q;

	logic [ltdm_pkg::PERIOD_W-1:0]  min_ms_q;
	logic [ltdm_pkg::PERIOD_W-1:0]  max_ms_q;

	logic signed [ltdm_pkg::ERR_W-1:0] err_q;
	logic                              on_q;
	logic                              steady_q;
	logic [ltdm_pkg::LEVEL_W-1:0]      target_q;
	logic [ltdm_pkg::TIME_W-1:0]       min_on_q;
	logic [ltdm_pkg::TIME_W-1:0]       min_off_q;
	logic [ltdm_pkg::TIME_W-1:0]       max_on_q;
	logic [ltdm_pkg::TIME_W-1:0]       max_off_q;
	logic [ltdm_pkg::HIGH_W-1:0]       high_q;
	logic signed [ltdm_pkg::LOW_W-1:0] low_q;
	logic signed [ltdm_pkg::SUM_W-1:0] sum_q;

	ltdm_pkg::op_t                  op_q;
	logic [ltdm_pkg::ELAPSED_W-1:0] elapsed_q;
	logic [ltdm_pkg::LEVEL_W-1:0]   bright_q;

	logic                 mul_start_q;
	logic                 div_start_q;
	logic                 out_valid_q;
	ltdm_pkg::out_word_t  out_q;

	logic [ltdm_pkg::TIME_W-1:0]  minp;
	logic [ltdm_pkg::TIME_W-1:0]  maxp;
	logic [ltdm_pkg::LEVEL_W-1:0] b_sat;

	logic [ltdm_pkg::MUL0_AW-1:0]             m0_a;
	logic [ltdm_pkg::MUL_BW-1:0]              m0_b;
	logic [ltdm_pkg::MUL0_AW+ltdm_pkg::MUL_BW-1:0] m0_p;
	logic                                     m0_done;
	logic [ltdm_pkg::MUL1_AW-1:0]             m1_a;
	logic [ltdm_pkg::MUL1_AW+ltdm_pkg::MUL_BW-1:0] m1_p;
	logic                                     m1_done;

	logic [ltdm_pkg::DIV0_NW-1:0] d0_n;
	logic [ltdm_pkg::DIV_DW-1:0]  d0_d;
	logic [ltdm_pkg::DIV0_NW-1:0] d0_q;
	logic [ltdm_pkg::DIV_DW-1:0]  d0_r;
	logic                         d0_done;
	logic [ltdm_pkg::DIV1_NW-1:0] d1_q;
	logic [ltdm_pkg::DIV_DW-1:0]  d1_r;
	logic                         d1_done;

	logic signed [ltdm_pkg::SUM_W-1:0] sum_next;
	logic signed [ltdm_pkg::ERR_W-1:0] err_clamped;
	logic [ltdm_pkg::ERR_W-1:0]        err_mag;
	logic                              new_on;
	logic [ltdm_pkg::LEVEL_W-1:0]      new_speed;
	logic [ltdm_pkg::ERR_W-1:0]        t_min;
	logic [ltdm_pkg::TIMEOUT_W-1:0]    timeout;

	assign minp  = ltdm_pkg::TIME_W'(min_ms_q) * ltdm_pkg::US_PER_MS;
	assign maxp  = ltdm_pkg::TIME_W'(max_ms_q) * ltdm_pkg::US_PER_MS;
	assign b_sat = (in_data.brightness > ltdm_pkg::ON_LEVEL) ? ltdm_pkg::ON_LEVEL
		: in_data.brightness;

	// operand select for the shared serial units
	always_comb begin
		unique case (state_q)
			S_MUL1: begin
				m0_a = ltdm_pkg::MUL0_AW'(maxp);
				m0_b = bright_q - ltdm_pkg::OFF_LEVEL;
				m1_a = minp;
			end
			S_MUL2: begin
				m0_a = ltdm_pkg::MUL0_AW'(max_on_q);
				m0_b = ltdm_pkg::ON_LEVEL - bright_q;
				m1_a = max_off_q;
			end
			default: begin
				m0_a = elapsed_q;
				m0_b = speed_of(on_q, target_q);
				m1_a = minp;
			end
		endcase
	end

	always_comb begin
		unique case (state_q)
			S_DIV1: begin
				d0_n = m0_p;
				d0_d = ltdm_pkg::SPAN;
			end
			default: begin
				d0_n = err_mag;
				d0_d = speed_of(on_q, target_q);
			end
		endcase
	end

	ltdm_mul #(
		.AW (ltdm_pkg::MUL0_AW),
		.BW (ltdm_pkg::MUL_BW)
	) u_mul0 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (m0_a),
		.b      (m0_b),
		.done   (m0_done),
		.p      (m0_p)
	);

	ltdm_mul #(
		.AW (ltdm_pkg::MUL1_AW),
		.BW (ltdm_pkg::MUL_BW)
	) u_mul1 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (m1_a),
		.b      (bright_q - ltdm_pkg::OFF_LEVEL),
		.done   (m1_done),
		.p      (m1_p)
	);

	ltdm_div #(
		.NW (ltdm_pkg::DIV0_NW),
		.DW (ltdm_pkg::DIV_DW)
	) u_div0 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.n      (d0_n),
		.d      (d0_d),
		.done   (d0_done),
		.q      (d0_q),
		.r      (d0_r)
	);

	ltdm_div #(
		.NW (ltdm_pkg::DIV1_NW),
		.DW (ltdm_pkg::DIV_DW)
	) u_div1 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.n      (m1_p),
		.d      (ltdm_pkg::SPAN),
		.done   (d1_done),
		.q      (d1_q),
		.r      (d1_r)
	);

	// accrual and clamp
	always_comb begin
		sum_next = $signed({{(ltdm_pkg::SUM_W-ltdm_pkg::ERR_W){err_q[ltdm_pkg::ERR_W-1]}}, err_q});
		if (on_q) begin
			sum_next = sum_next + $signed({2'b0, m0_p});
		end else begin
			sum_next = sum_next - $signed({2'b0, m0_p});
		end
	end

	always_comb begin
		priority if (sum_q < $signed({{(ltdm_pkg::SUM_W-ltdm_pkg::LOW_W){low_q[ltdm_pkg::LOW_W-1]}},
			low_q})) begin
			err_clamped = {low_q[ltdm_pkg::LOW_W-1], low_q};
		end else if (sum_q > $signed({{(ltdm_pkg::SUM_W-ltdm_pkg::HIGH_W){1'b0}}, high_q})) begin
			err_clamped = {2'b0, high_q};
		end else begin
			err_clamped = sum_q[ltdm_pkg::ERR_W-1:0];
		end
	end

	assign err_mag   = err_q[ltdm_pkg::ERR_W-1] ? ltdm_pkg::ERR_W'(-err_q) : err_q;
	assign new_on    = err_q[ltdm_pkg::ERR_W-1]
		|| ((err_q == '0) && (target_q > ltdm_pkg::HALF_LEVEL));
	assign new_speed = speed_of(new_on, target_q);

	// timeout from the quotient, minimum times and field range; zero when steady
	always_comb begin
		t_min = d0_q;
		if (on_q && (min_on_q >= min_off_q) && (d0_q < ltdm_pkg::ERR_W'(min_on_q))) begin
			t_min = ltdm_pkg::ERR_W'(min_on_q);
		end
		if (!on_q && (min_off_q >= min_on_q) && (d0_q < ltdm_pkg::ERR_W'(min_off_q))) begin
			t_min = ltdm_pkg::ERR_W'(min_off_q);
		end
		if (steady_q) begin
			timeout = '0;
		end else if (t_min > ltdm_pkg::ERR_W'(ltdm_pkg::TIMEOUT_MAX)) begin
			timeout = ltdm_pkg::TIMEOUT_MAX;
		end else begin
			timeout = t_min[ltdm_pkg::TIMEOUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_ms_q <= ltdm_pkg::MIN_PERIOD_RST;
			max_ms_q <= ltdm_pkg::MAX_PERIOD_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ltdm_pkg::CFG_MIN_PERIOD: min_ms_q <= cfg_data;
				ltdm_pkg::CFG_MAX_PERIOD: max_ms_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			err_q       <= '0;
			on_q        <= 1'b0;
			steady_q    <= 1'b0;
			target_q    <= ltdm_pkg::OFF_LEVEL;
			min_on_q    <= '0;
			min_off_q   <= ltdm_pkg::MIN_OFF_RST;
			max_on_q    <= '0;
			max_off_q   <= '0;
			high_q      <= '0;
			low_q       <= '0;
			sum_q       <= '0;
			op_q        <= ltdm_pkg::OP_TIME;
			elapsed_q   <= '0;
			bright_q    <= '0;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			mul_start_q <= ((state_q == S_IDLE) && in_valid)
				|| ((state_q == S_DIV1) && d0_done)
				|| ((state_q == S_MUL2) && m0_done && m1_done);
			div_start_q <= ((state_q == S_MUL1) && m0_done && m1_done)
				|| ((state_q == S_CHOOSE) && (new_speed != '0));
			if (out_valid_q && out_ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q        <= in_data.opcode;
						elapsed_q   <= in_data.elapsed_us;
						bright_q    <= b_sat;
						state_q     <= (in_data.opcode == ltdm_pkg::OP_SET) ? S_MUL1 : S_ACC;
					end
				end
				S_MUL1: begin
					if (m0_done && m1_done) begin
						state_q     <= S_DIV1;
					end
				end
				S_DIV1: begin
					if (d1_done) begin
						min_on_q    <= d1_q[ltdm_pkg::TIME_W-1:0];
						min_off_q   <= minp - d1_q[ltdm_pkg::TIME_W-1:0]
							- ltdm_pkg::TIME_W'(d1_r != '0);
					end
					if (d0_done) begin
						max_on_q    <= d0_q[ltdm_pkg::TIME_W-1:0];
						max_off_q   <= maxp - d0_q[ltdm_pkg::TIME_W-1:0]
							- ltdm_pkg::TIME_W'(d0_r != '0);
						state_q     <= S_MUL2;
					end
				end
				S_MUL2: begin
					if (m0_done && m1_done) begin
						high_q      <= m0_p[ltdm_pkg::HIGH_W-1:0];
						low_q       <= ltdm_pkg::LOW_W'(0) - ltdm_pkg::LOW_W'(m1_p);
						state_q     <= S_ACC;
					end
				end
				S_ACC: begin
					if (m0_done) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					sum_q   <= sum_next;
					state_q <= S_CLAMP;
				end
				S_CLAMP: begin
					err_q <= err_clamped;
					if (op_q == ltdm_pkg::OP_SET) begin
						target_q <= bright_q;
					end
					state_q <= S_CHOOSE;
				end
				S_CHOOSE: begin
					on_q     <= new_on;
					steady_q <= (new_speed == '0);
					if (new_speed == '0) begin
						state_q <= S_FIN;
					end else begin
						state_q     <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (d0_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_q.led_on     <= on_q;
						out_q.steady     <= steady_q;
						out_q.timeout_us <= timeout;
						out_valid_q      <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// File: hw/rtl/ltdm_checker.sv
`default_nettype none

`include "led_time_dither_modulator_top_defines.svh"

module ltdm_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire ltdm_pkg::out_word_t            out_data,
	input wire logic                           cfg_valid,
	input wire logic                           cfg_ready
);

	// a result word waiting on the output holds
	`LTDM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output word changed while stalled")

	// one word in flight at a time
	`LTDM_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "input taken while busy")

	// steady result carries no timeout
	`LTDM_ASSERT_SAME(a_steady_zero, out_valid && out_data.steady, out_data.timeout_us == '0, "steady word with nonzero timeout")

	// configuration port never stalls
	`LTDM_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready, "configuration write stalled")

endmodule

bind led_time_dither_modulator_top ltdm_checker u_ltdm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

`default_nettype wire
